/* rtl/core/qrs_pkg.sv */
// shared constants, types and field layout for the quadratic root solver
`default_nettype none

package qrs_pkg;

    // default arithmetic format
    localparam int COEF_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    // fixed port field widths
    localparam int FIELD_W       = 32;
    localparam int DISC_W        = 64;
    localparam int TOL_W         = 16;
    localparam int KIND_W        = 3;
    localparam int IN_TDATA_W    = 96;
    localparam int OUT_TDATA_W   = 136;
    localparam logic [TOL_W-1:0] TOL_RESET = 16'd1;

    // saturation limits of the discriminant output
    localparam logic [DISC_W-1:0] DISC_POS_LIM = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [DISC_W-1:0] DISC_NEG_LIM = 64'h8000_0000_0000_0000;

    // solution kind codes
    typedef enum logic [KIND_W-1:0] {
        KIND_NONE     = 3'd0,
        KIND_INFINITE = 3'd1,
        KIND_LINEAR   = 3'd2,
        KIND_DOUBLE   = 3'd3,
        KIND_TWO      = 3'd4,
        KIND_NO_REAL  = 3'd5
    } kind_t;

    // per-item sideband carried along the pipeline
    typedef struct packed {
        kind_t                     kind;
        logic signed [FIELD_W-1:0] a;
        logic signed [FIELD_W-1:0] b;
        logic signed [FIELD_W-1:0] c;
        logic [DISC_W-1:0]         dout;
        logic                      sat;
    } side_t;

endpackage

`default_nettype wire

/* rtl/core/qrs_front.sv */
// front end: coefficient capture, products, discriminant and classification
`default_nettype none

module qrs_front
    import qrs_pkg::*;
#(
    parameter int COEF_WIDTH = COEF_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        en,
    input  wire logic [TOL_W-1:0]            tol,
    input  wire logic                        in_valid,
    input  wire logic [FIELD_W-1:0]          in_a,
    input  wire logic [FIELD_W-1:0]          in_b,
    input  wire logic [FIELD_W-1:0]          in_c,
    output logic                             out_valid,
    output side_t                            out_side,
    output logic [2*COEF_WIDTH+1:0]          out_rad
);

    localparam int CW   = COEF_WIDTH;
    localparam int P_W  = 2 * CW;
    localparam int DM_W = 2 * CW + 2;
    localparam int SC_W = (DM_W > DISC_W ? DM_W : DISC_W) + 1;
    localparam int NZ_W = (DM_W > TOL_W + FRAC_BITS) ? DM_W : TOL_W + FRAC_BITS;

    // stage 1: coefficients cut to the working width
    logic                 v1_reg;
    logic signed [CW-1:0] a1_reg, b1_reg, c1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en)
            v1_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1_reg <= signed'(in_a[CW-1:0]);
            b1_reg <= signed'(in_b[CW-1:0]);
            c1_reg <= signed'(in_c[CW-1:0]);
        end
    end

    // magnitudes and zero tests
    logic [CW-1:0] ma, mb, mc, tolc;

    always_comb
    begin
        ma   = a1_reg[CW-1] ? CW'(-a1_reg) : CW'(a1_reg);
        mb   = b1_reg[CW-1] ? CW'(-b1_reg) : CW'(b1_reg);
        mc   = c1_reg[CW-1] ? CW'(-c1_reg) : CW'(c1_reg);
        tolc = CW'(tol);
    end

    // stage 2: b*b and |a|*|c|
    logic                 v2_reg;
    logic [P_W-1:0]       bb2_reg, m2_reg;
    logic [P_W-1:0]       bb2_next, m2_next;
    logic                 za2_reg, zb2_reg, zc2_reg, same2_reg;
    logic signed [CW-1:0] a2_reg, b2_reg, c2_reg;

    always_comb
    begin
        bb2_next = mb * mb;
        m2_next  = ma * mc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (en)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bb2_reg   <= bb2_next;
            m2_reg    <= m2_next;
            za2_reg   <= ma < tolc;
            zb2_reg   <= mb < tolc;
            zc2_reg   <= mc < tolc;
            same2_reg <= a1_reg[CW-1] == c1_reg[CW-1];
            a2_reg    <= a1_reg;
            b2_reg    <= b1_reg;
            c2_reg    <= c1_reg;
        end
    end

    // discriminant magnitude and sign, output clamp, kind
    logic [DM_W-1:0]   f, bbx, dm;
    logic              dneg, dsat, near;
    logic [SC_W-1:0]   dmw;
    logic [DISC_W-1:0] dval;
    side_t             side3_next;

    always_comb
    begin
        f   = {m2_reg, 2'b00};
        bbx = DM_W'(bb2_reg);
        if (same2_reg)
        begin
            if (f <= bbx)
            begin
                dneg = 1'b0;
                dm   = bbx - f;
            end
            else
            begin
                dneg = 1'b1;
                dm   = f - bbx;
            end
        end
        else
        begin
            dneg = 1'b0;
            dm   = bbx + f;
        end

        dmw = SC_W'(dm);
        if (!dneg)
        begin
            dsat = dmw > SC_W'(DISC_POS_LIM);
            dval = dsat ? DISC_POS_LIM : DISC_W'(dm);
        end
        else
        begin
            dsat = dmw > SC_W'(DISC_NEG_LIM);
            dval = dsat ? DISC_NEG_LIM : DISC_W'(0) - DISC_W'(dm);
        end

        near = NZ_W'(dm) < (NZ_W'(tol) << FRAC_BITS);

        side3_next.a    = FIELD_W'(a2_reg);
        side3_next.b    = FIELD_W'(b2_reg);
        side3_next.c    = FIELD_W'(c2_reg);
        side3_next.dout = '0;
        side3_next.sat  = 1'b0;
        if (za2_reg)
        begin
            if (zb2_reg)
                side3_next.kind = zc2_reg ? KIND_INFINITE : KIND_NONE;
            else
                side3_next.kind = KIND_LINEAR;
        end
        else
        begin
            side3_next.dout = dval;
            side3_next.sat  = dsat;
            if (near)
                side3_next.kind = KIND_DOUBLE;
            else if (!dneg)
                side3_next.kind = KIND_TWO;
            else
                side3_next.kind = KIND_NO_REAL;
        end
    end

    // stage 3 registers
    logic            v3_reg;
    side_t           side3_reg;
    logic [DM_W-1:0] rad3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (en)
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side3_reg <= side3_next;
            rad3_reg  <= dm;
        end
    end

    assign out_valid = v3_reg;
    assign out_side  = side3_reg;
    assign out_rad   = rad3_reg;

endmodule

`default_nettype wire

/* rtl/core/qrs_sqrt.sv */
// pipelined floor square root, one root bit per stage
`default_nettype none

module qrs_sqrt
    import qrs_pkg::*;
#(
    parameter int COEF_WIDTH = COEF_WIDTH_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      en,
    input  wire logic                      in_valid,
    input  wire side_t                     in_side,
    input  wire logic [2*COEF_WIDTH+1:0]   in_rad,
    output logic                           out_valid,
    output side_t                          out_side,
    output logic [COEF_WIDTH:0]            out_root
);

    localparam int SQ_W = COEF_WIDTH + 1;
    localparam int X_W  = 2 * SQ_W;
    localparam int RW   = SQ_W + 2;

    logic            v_reg    [SQ_W];
    side_t           side_reg [SQ_W];
    logic [X_W-1:0]  x_reg    [SQ_W];
    logic [RW-1:0]   rem_reg  [SQ_W];
    logic [SQ_W-1:0] root_reg [SQ_W];

    logic            v_src    [SQ_W];
    side_t           side_src [SQ_W];
    logic [X_W-1:0]  x_src    [SQ_W];
    logic [RW-1:0]   rem_src  [SQ_W];
    logic [SQ_W-1:0] root_src [SQ_W];

    for (genvar k = 0; k < SQ_W; k++)
    begin : g_stage
        logic [RW-1:0]   cur, trial, rem_next;
        logic [SQ_W-1:0] root_next;

        // stage inputs
        if (k == 0)
        begin : g_first
            assign v_src[k]    = in_valid;
            assign side_src[k] = in_side;
            assign x_src[k]    = in_rad;
            assign rem_src[k]  = '0;
            assign root_src[k] = '0;
        end
        else
        begin : g_next
            assign v_src[k]    = v_reg[k-1];
            assign side_src[k] = side_reg[k-1];
            assign x_src[k]    = x_reg[k-1];
            assign rem_src[k]  = rem_reg[k-1];
            assign root_src[k] = root_reg[k-1];
        end

        // bring down two radicand bits, try root bit one
        always_comb
        begin
            cur   = {rem_src[k][RW-3:0], x_src[k][2*(SQ_W-1-k) +: 2]};
            trial = {root_src[k], 2'b01};
            if (cur >= trial)
            begin
                rem_next  = cur - trial;
                root_next = {root_src[k][SQ_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = cur;
                root_next = {root_src[k][SQ_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k] <= 1'b0;
            else if (en)
                v_reg[k] <= v_src[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[k] <= side_src[k];
                x_reg[k]    <= x_src[k];
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
            end
        end
    end

    assign out_valid = v_reg[SQ_W-1];
    assign out_side  = side_reg[SQ_W-1];
    assign out_root  = root_reg[SQ_W-1];

endmodule

`default_nettype wire

/* rtl/core/qrs_div.sv */
// two-lane pipelined fixed-point divider with root selection and clamping
`default_nettype none

module qrs_div
    import qrs_pkg::*;
#(
    parameter int COEF_WIDTH = COEF_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire logic [TOL_W-1:0]     tol,
    input  wire logic                 in_valid,
    input  wire side_t                in_side,
    input  wire logic [COEF_WIDTH:0]  in_root,
    output logic                      out_valid,
    output kind_t                     out_kind,
    output logic [FIELD_W-1:0]        out_root_first,
    output logic [FIELD_W-1:0]        out_root_second,
    output logic [DISC_W-1:0]         out_disc,
    output logic                      out_sat
);

    localparam int CW    = COEF_WIDTH;
    localparam int NS_W  = CW + 2;
    localparam int NUM_W = CW + 1;
    localparam int DV_W  = NUM_W + FRAC_BITS;
    localparam int H_W   = DV_W - CW;
    localparam int HC_W  = (H_W > NUM_W) ? H_W : NUM_W;

    // numerator and denominator per kind
    logic signed [NS_W-1:0] ax, bx, cx, sx;
    logic signed [NS_W-1:0] num [2];
    logic signed [NS_W-1:0] den;

    always_comb
    begin
        ax  = NS_W'(in_side.a);
        bx  = NS_W'(in_side.b);
        cx  = NS_W'(in_side.c);
        sx  = signed'({1'b0, in_root});
        den = ax <<< 1;
        unique case (in_side.kind)
            KIND_LINEAR:
            begin
                num[0] = -cx;
                num[1] = '0;
                den    = bx;
            end
            KIND_DOUBLE:
            begin
                num[0] = -bx;
                num[1] = '0;
            end
            KIND_TWO:
            begin
                num[0] = sx - bx;
                num[1] = -bx - sx;
            end
            default:
            begin
                num[0] = '0;
                num[1] = '0;
            end
        endcase
    end

    // stage 0: magnitudes and quotient sign
    logic             v0_reg;
    side_t            side0_reg;
    logic [NUM_W-1:0] un0_reg [2];
    logic [NUM_W-1:0] ud0_reg [2];
    logic             neg0_reg [2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else if (en)
            v0_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            side0_reg <= in_side;
    end

    // shared valid and sideband along the quotient stages
    logic  vs_reg    [CW+1];
    side_t sides_reg [CW+1];

    for (genvar j = 0; j <= CW; j++)
    begin : g_side
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vs_reg[j] <= 1'b0;
            else if (en)
                vs_reg[j] <= (j == 0) ? v0_reg : vs_reg[(j == 0) ? 0 : j-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
                sides_reg[j] <= (j == 0) ? side0_reg : sides_reg[(j == 0) ? 0 : j-1];
        end
    end

    logic [NUM_W-1:0] rem_reg [2][CW+1];
    logic [NUM_W-1:0] ud_reg  [2][CW+1];
    logic [CW-1:0]    q_reg   [2][CW+1];
    logic [CW-1:0]    lo_reg  [2][CW+1];
    logic             neg_reg [2][CW+1];
    logic             nz_reg  [2][CW+1];
    logic             ovf_reg [2][CW+1];

    logic [CW-1:0]    r_fin    [2];
    logic             over_fin [2];

    for (genvar l = 0; l < 2; l++)
    begin : g_lane
        logic [NUM_W-1:0] un_next, ud_next;
        logic [DV_W-1:0]  dvd;
        logic [H_W-1:0]   hi_part;
        logic             nz1_next, ovf1_next;

        // operand magnitudes
        always_comb
        begin
            un_next = num[l][NS_W-1] ? NUM_W'(-num[l]) : NUM_W'(num[l]);
            ud_next = den[NS_W-1] ? NUM_W'(-den) : NUM_W'(den);
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                un0_reg[l]  <= un_next;
                ud0_reg[l]  <= ud_next;
                neg0_reg[l] <= num[l][NS_W-1] != den[NS_W-1];
            end
        end

        // quotient overflow check on the upper dividend part
        always_comb
        begin
            dvd       = {un0_reg[l], {FRAC_BITS{1'b0}}};
            hi_part   = dvd[DV_W-1:CW];
            nz1_next  = un0_reg[l] != '0;
            ovf1_next = nz1_next && (HC_W'(hi_part) >= HC_W'(ud0_reg[l]));
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[l][0] <= NUM_W'(hi_part);
                ud_reg[l][0]  <= ud0_reg[l];
                q_reg[l][0]   <= '0;
                lo_reg[l][0]  <= dvd[CW-1:0];
                neg_reg[l][0] <= neg0_reg[l];
                nz_reg[l][0]  <= nz1_next;
                ovf_reg[l][0] <= ovf1_next;
            end
        end

        // restoring division, one quotient bit per stage
        for (genvar k = 0; k < CW; k++)
        begin : g_bit
            logic [NUM_W:0]   cur;
            logic             ge;
            logic [NUM_W-1:0] rem_next;

            always_comb
            begin
                cur      = {rem_reg[l][k], lo_reg[l][k][CW-1-k]};
                ge       = cur >= {1'b0, ud_reg[l][k]};
                rem_next = ge ? NUM_W'(cur - {1'b0, ud_reg[l][k]}) : NUM_W'(cur);
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[l][k+1] <= rem_next;
                    ud_reg[l][k+1]  <= ud_reg[l][k];
                    q_reg[l][k+1]   <= {q_reg[l][k][CW-2:0], ge};
                    lo_reg[l][k+1]  <= lo_reg[l][k];
                    neg_reg[l][k+1] <= neg_reg[l][k];
                    nz_reg[l][k+1]  <= nz_reg[l][k];
                    ovf_reg[l][k+1] <= ovf_reg[l][k];
                end
            end
        end

        // clamp, apply sign, flush tiny roots
        logic [CW-1:0] lim, qc;
        logic          over;

        always_comb
        begin
            lim  = neg_reg[l][CW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
            over = nz_reg[l][CW] && (ovf_reg[l][CW] || (q_reg[l][CW] > lim));
            if (!nz_reg[l][CW])
                qc = '0;
            else if (over)
                qc = lim;
            else
                qc = q_reg[l][CW];
            if (qc < CW'(tol))
                r_fin[l] = '0;
            else
                r_fin[l] = neg_reg[l][CW] ? CW'(-qc) : qc;
            over_fin[l] = over;
        end
    end

    // result register
    logic              vf_reg;
    kind_t             kind_f_reg;
    logic [FIELD_W-1:0] r1_reg, r2_reg;
    logic [DISC_W-1:0] disc_reg;
    logic              sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vf_reg <= 1'b0;
        else if (en)
            vf_reg <= vs_reg[CW];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            kind_f_reg <= sides_reg[CW].kind;
            r1_reg     <= FIELD_W'(signed'(r_fin[0]));
            r2_reg     <= FIELD_W'(signed'(r_fin[1]));
            disc_reg   <= sides_reg[CW].dout;
            sat_reg    <= sides_reg[CW].sat | over_fin[0] | over_fin[1];
        end
    end

    assign out_valid       = vf_reg;
    assign out_kind        = kind_f_reg;
    assign out_root_first  = r1_reg;
    assign out_root_second = r2_reg;
    assign out_disc        = disc_reg;
    assign out_sat         = sat_reg;

endmodule

`default_nettype wire

/* rtl/core/quadratic_root_solver.sv */
// top level of the quadratic root solver: tolerance register, pipeline and stream ports
`default_nettype none

// Solves a*x*x + b*x + c = 0 for signed fixed-point coefficients, one
// coefficient set per clock while no result waits on m_tready. The pipeline
// has three front stages (capture, products, discriminant), one square root stage
// per root bit and a divider with a select stage, an overflow stage, one stage
// per quotient bit and a result stage. The whole pipeline advances together
// and holds while a result waits on m_tready. zero_tolerance is written through
// the cfg channel, which is always ready, and may only change while the
// pipeline is empty.
module quadratic_root_solver
    import qrs_pkg::*;
#(
    parameter int COEF_WIDTH = COEF_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // configuration: zero_tolerance
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [TOL_W-1:0]       cfg_data,
    // coefficients
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,  // coef_a, coef_b, coef_c
    // results
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [KIND_W-1:0]           m_tuser,  // solution_kind
    output logic [OUT_TDATA_W-1:0]      m_tdata   // root_first, root_second,
                                                  // discriminant_value, saturated
);

    // tolerance register
    logic [TOL_W-1:0] tol_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tol_reg <= TOL_RESET;
        else if (cfg_valid && cfg_ready)
            tol_reg <= cfg_data;
    end

    // pipeline advance
    logic adv;

    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    logic                    fr_valid;
    side_t                   fr_side;
    logic [2*COEF_WIDTH+1:0] fr_rad;

    qrs_front #(
        .COEF_WIDTH (COEF_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .tol       (tol_reg),
        .in_valid  (s_tvalid),
        .in_a      (s_tdata[31:0]),
        .in_b      (s_tdata[63:32]),
        .in_c      (s_tdata[95:64]),
        .out_valid (fr_valid),
        .out_side  (fr_side),
        .out_rad   (fr_rad)
    );

    logic                sq_valid;
    side_t               sq_side;
    logic [COEF_WIDTH:0] sq_root;

    qrs_sqrt #(
        .COEF_WIDTH (COEF_WIDTH)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (fr_valid),
        .in_side   (fr_side),
        .in_rad    (fr_rad),
        .out_valid (sq_valid),
        .out_side  (sq_side),
        .out_root  (sq_root)
    );

    kind_t              res_kind;
    logic [FIELD_W-1:0] res_r1, res_r2;
    logic [DISC_W-1:0]  res_disc;
    logic               res_sat;

    qrs_div #(
        .COEF_WIDTH (COEF_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_div (
        .clk             (clk),
        .rst_n           (rst_n),
        .en              (adv),
        .tol             (tol_reg),
        .in_valid        (sq_valid),
        .in_side         (sq_side),
        .in_root         (sq_root),
        .out_valid       (m_tvalid),
        .out_kind        (res_kind),
        .out_root_first  (res_r1),
        .out_root_second (res_r2),
        .out_disc        (res_disc),
        .out_sat         (res_sat)
    );

    // result packing
    assign m_tuser = res_kind;
    assign m_tdata = {7'd0, res_sat, res_disc, res_r2, res_r1};

    // kinds without roots carry zero roots
    a_no_roots: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_NONE || m_tuser == KIND_INFINITE ||
                     m_tuser == KIND_NO_REAL) |-> m_tdata[63:0] == '0)
        else $error("roots present for a rootless kind");

    // discriminant only reported for quadratic kinds
    a_disc_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_NONE || m_tuser == KIND_INFINITE ||
                     m_tuser == KIND_LINEAR) |-> m_tdata[127:64] == '0)
        else $error("discriminant set for a non-quadratic kind");

    // second root only for two distinct roots
    a_second_root: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[63:32] != '0) |-> m_tuser == KIND_TWO)
        else $error("second root set outside two-root kind");

endmodule

`default_nettype wire

/* tb/quadratic_root_solver_tb.sv */
// testbench for the quadratic root solver: directed and random coefficient sets checked against a predictor
`timescale 1ns / 1ps

module quadratic_root_solver_tb
    import qrs_pkg::*;
();

    localparam int LATENCY    = 71;
    localparam int WATCH_LIM  = 20000;

    typedef struct {
        kind_t             kind;
        logic [31:0]       root1;
        logic [31:0]       root2;
        logic [63:0]       disc;
        logic              sat;
    } solution_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [TOL_W-1:0]       cfg_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [KIND_W-1:0]      m_tuser;
    logic [OUT_TDATA_W-1:0] m_tdata;

    logic [15:0]  tolerance;
    solution_t    expected_solutions[$];
    int           error_count;
    int           items_sent;
    int           results_seen;
    int           idle_cycles;
    bit           hold_off_req;
    bit           random_sink;
    int           kind_hits[6];

    quadratic_root_solver u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tuser   (m_tuser),
        .m_tdata   (m_tdata)
    );

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // magnitude of a signed 64-bit value as unsigned
    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        mag64 = v[63] ? -v : v;
    endfunction

    // floor square root of a value below 2^66
    function automatic logic [63:0] floor_sqrt(input logic [127:0] v);
        logic [63:0]  r;
        logic [63:0]  t;
        r = 0;
        for (int i = 33; i >= 0; i--)
        begin
            t = r | (64'd1 << i);
            if ({64'd0, t} * {64'd0, t} <= v)
                r = t;
        end
        floor_sqrt = r;
    endfunction

    // (num << 16) / den toward zero, clamped to 32 bits
    function automatic logic signed [63:0] fix_divide(input logic signed [63:0] num,
                                                      input logic signed [63:0] den,
                                                      inout logic sat);
        logic [63:0]  un;
        logic [63:0]  ud;
        logic [127:0] q;
        logic         neg;
        logic [63:0]  lim;
        un  = mag64(num);
        ud  = mag64(den);
        neg = num[63] != den[63];
        lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
        if (ud == 0)
        begin
            if (un == 0)
                return 0;
            sat = 1'b1;
            q = lim;
        end
        else
        begin
            q = ({64'd0, un} << 16) / ud;
            if (q > lim)
            begin
                q = lim;
                sat = 1'b1;
            end
        end
        fix_divide = neg ? -$signed(q[63:0]) : $signed(q[63:0]);
    endfunction

    // expected solution of one coefficient set
    function automatic solution_t solve_quadratic(input logic [31:0] ra, input logic [31:0] rb,
                                                  input logic [31:0] rc);
        solution_t              s;
        logic signed [63:0]     a;
        logic signed [63:0]     b;
        logic signed [63:0]     c;
        logic signed [63:0]     r1;
        logic signed [63:0]     r2;
        logic signed [63:0]     sq;
        logic signed [127:0]    d;
        logic [127:0]           dm;
        logic                   sat;
        a = $signed(ra); b = $signed(rb); c = $signed(rc);
        r1 = 0; r2 = 0; sat = 0;
        s.disc = 0;
        if (mag64(a) < tolerance)
        begin
            if (mag64(b) < tolerance)
                s.kind = (mag64(c) < tolerance) ? KIND_INFINITE : KIND_NONE;
            else
            begin
                s.kind = KIND_LINEAR;
                r1 = fix_divide(-c, b, sat);
            end
        end
        else
        begin
            d  = 128'(b) * 128'(b) - 128'sd4 * 128'(a) * 128'(c);
            dm = d[127] ? -d : d;
            if (d > 128'sh7FFF_FFFF_FFFF_FFFF)
            begin
                s.disc = DISC_POS_LIM;
                sat = 1'b1;
            end
            else if (d < -128'sh8000_0000_0000_0000)
            begin
                s.disc = DISC_NEG_LIM;
                sat = 1'b1;
            end
            else
                s.disc = d[63:0];
            if (dm < ({112'd0, tolerance} << 16))
            begin
                s.kind = KIND_DOUBLE;
                r1 = fix_divide(-b, 2 * a, sat);
            end
            else if (!d[127])
            begin
                sq = $signed(floor_sqrt(dm));
                s.kind = KIND_TWO;
                r1 = fix_divide(-b + sq, 2 * a, sat);
                r2 = fix_divide(-b - sq, 2 * a, sat);
            end
            else
                s.kind = KIND_NO_REAL;
        end
        if (mag64(r1) < tolerance) r1 = 0;
        if (mag64(r2) < tolerance) r2 = 0;
        s.root1 = r1[31:0];
        s.root2 = r2[31:0];
        s.sat   = sat;
        solve_quadratic = s;
    endfunction

    // send one coefficient set after a random gap, or at once when no_gap is set
    task automatic send_coefs(input logic [31:0] a, input logic [31:0] b, input logic [31:0] c,
                              input bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 9);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {c, b, a};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_solutions.push_back(solve_quadratic(a, b, c));
        items_sent++;
        @(negedge clk);
    endtask

    // lower valid and wait until every expected result has come
    task automatic drain;
        s_tvalid <= 1'b0;
        while (expected_solutions.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 5) @(negedge clk);
    endtask

    task automatic write_tolerance(input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        tolerance = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // random coefficient with a mix of magnitudes
    function automatic logic [31:0] rand_coef();
        case ($urandom_range(0, 5))
            0: rand_coef = $urandom();
            1: rand_coef = $signed($urandom_range(0, 8)) - 4;
            2: rand_coef = ($urandom_range(0, 1) ? 32'hFFFF_0000 : 32'd0)
                           ^ $urandom_range(0, 32'h0008_0000);
            3: rand_coef = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            default: rand_coef = $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
        endcase
    endfunction

    task automatic test_directed;
        send_coefs(32'h0001_0000, 32'hFFFD_0000, 32'h0002_0000);  // two roots 1 and 2
        send_coefs(32'h0001_0000, 32'hFFFE_0000, 32'h0001_0000);  // double root
        send_coefs(32'h0001_0000, 32'd0, 32'h0001_0000);          // no real roots
        send_coefs(32'd0, 32'h0002_0000, 32'hFFFC_0000);          // linear
        send_coefs(32'd0, 32'd0, 32'd0);                          // infinite
        send_coefs(32'd0, 32'd0, 32'h0000_0005);                  // none
        send_coefs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_coefs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_coefs(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);  // discriminant clamps
        send_coefs(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
        send_coefs(32'h0000_0001, 32'h7FFF_FFFF, 32'h0000_0001);  // roots clamp
        send_coefs(32'd0, 32'h0000_0001, 32'h8000_0000);          // linear root clamps
        send_coefs(32'h0000_0001, 32'h0000_0002, 32'h0000_0001);  // near-zero discriminant
        send_coefs(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
        send_coefs(32'h0001_0000, 32'h0000_0001, 32'h0000_0000);  // tiny root becomes zero
        send_coefs(32'hFFFF_0000, 32'h0003_0000, 32'h0004_0000);
        drain();
    endtask

    // tolerance zero opens the division by zero cases; the largest tolerance follows
    task automatic test_tolerance_extremes;
        write_tolerance(16'd0);
        send_coefs(32'd0, 32'd0, 32'd0);
        send_coefs(32'd0, 32'd0, 32'h0000_0003);
        send_coefs(32'd0, 32'd0, 32'hFFFF_FFFD);
        send_coefs(32'd0, 32'h0001_0000, 32'd0);
        for (int i = 0; i < 40; i++)
            send_coefs(rand_coef(), rand_coef(), rand_coef());
        drain();
        write_tolerance(16'hFFFF);
        send_coefs(32'h0000_FFFE, 32'h0000_FFFF, 32'h0001_0000);
        send_coefs(32'h0001_0000, 32'h0000_8000, 32'hFFFF_0000);
        for (int i = 0; i < 40; i++)
            send_coefs(rand_coef(), rand_coef(), rand_coef());
        drain();
    endtask

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++)
        begin
            if (i % 150 == 0)
            begin
                drain();
                write_tolerance(16'($urandom_range(0, 3) == 0 ? $urandom_range(0, 16'hFFFF)
                                                              : $urandom_range(0, 8)));
            end
            send_coefs(rand_coef(), rand_coef(), rand_coef());
        end
        drain();
    endtask

    // receiver holds off while the sender keeps offering back to back
    task automatic test_backpressure;
        random_sink  = 0;
        hold_off_req = 1;
        for (int i = 0; i < 120; i++)
            send_coefs(rand_coef(), rand_coef(), rand_coef(), 1);
        random_sink = 1;
        drain();
    endtask

    // receiver ready control: a random wait per result, or a long hold-off on request
    initial
    begin
        int stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                m_tready <= 1'b0;
                repeat (400) @(negedge clk);
                hold_off_req = 0;
                m_tready <= 1'b1;
                while (!random_sink)
                    @(negedge clk);
            end
            else
            begin
                stall = $urandom_range(0, 9);
                if (stall != 0)
                begin
                    m_tready <= 1'b0;
                    repeat (stall) @(negedge clk);
                end
                m_tready <= 1'b1;
                do
                    @(posedge clk);
                while (!(m_tvalid && m_tready));
            end
        end
    end

    // result checker
    always @(posedge clk)
    begin
        solution_t exp_sol;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (expected_solutions.size() == 0)
            begin
                $error("result with no expected solution pending");
                error_count++;
            end
            else
            begin
                exp_sol = expected_solutions.pop_front();
                kind_hits[exp_sol.kind]++;
                if (m_tuser !== exp_sol.kind)
                begin
                    $error("solution_kind exp %0d got %0d", exp_sol.kind, m_tuser);
                    error_count++;
                end
                if (m_tdata[31:0] !== exp_sol.root1)
                begin
                    $error("root_first exp %h got %h", exp_sol.root1, m_tdata[31:0]);
                    error_count++;
                end
                if (m_tdata[63:32] !== exp_sol.root2)
                begin
                    $error("root_second exp %h got %h", exp_sol.root2, m_tdata[63:32]);
                    error_count++;
                end
                if (m_tdata[127:64] !== exp_sol.disc)
                begin
                    $error("discriminant_value exp %h got %h", exp_sol.disc, m_tdata[127:64]);
                    error_count++;
                end
                if (m_tdata[128] !== exp_sol.sat)
                begin
                    $error("saturated exp %b got %b", exp_sol.sat, m_tdata[128]);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCH_LIM)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        tolerance    = TOL_RESET;
        error_count  = 0;
        items_sent   = 0;
        results_seen = 0;
        idle_cycles  = 0;
        hold_off_req = 0;
        random_sink  = 1;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_tolerance_extremes();
        write_tolerance(16'd1);
        test_backpressure();
        test_random(560);
        $display("sent %0d coefficient sets, checked %0d results", items_sent, results_seen);
        $display("kinds none/inf/linear/double/two/noreal: %0d %0d %0d %0d %0d %0d",
                 kind_hits[0], kind_hits[1], kind_hits[2], kind_hits[3], kind_hits[4],
                 kind_hits[5]);
        if (error_count == 0 && expected_solutions.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

/* files.f */
rtl/core/qrs_pkg.sv
rtl/core/qrs_front.sv
rtl/core/qrs_sqrt.sv
rtl/core/qrs_div.sv
rtl/core/quadratic_root_solver.sv
tb/quadratic_root_solver_tb.sv
